/* src/sdd_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and calendar tables for the signed date difference block
// no dependencies
package sdd_pkg;

  localparam int MAX_YEAR_DEF = 9999;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DOY_W   = 9;
  localparam int Q100_W  = 8;
  localparam int DN_W    = 23;
  localparam int DIFF_W  = 23;

  // floor(x / 100) = (x * 5243) >> 19, exact for x < 2**14
  localparam logic [12:0] RECIP100   = 13'd5243;
  localparam int          RECIP_SHFT = 19;
  localparam int          PROD_W     = YEAR_W + 13;

  localparam logic [DIFF_W:0] DIFF_LIMIT = 24'd4194303;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               include_end_day;
  } sdd_in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     date_invalid;
  } sdd_out_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } sdd_adv_t;

  // days before the first of the month in a march-based year
  function automatic logic [DOY_W-1:0] month_base(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] b;
    case (m)
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* src/sdd_lane.sv */
`timescale 1ns / 1ps
// one date lane: checks the date and turns it into a day number over two stages
// depends on sdd_pkg
module sdd_lane #(
  parameter int MAX_YEAR = sdd_pkg::MAX_YEAR_DEF
) (
  input  logic                        clk,
  input  sdd_pkg::sdd_adv_t           adv,
  input  logic [sdd_pkg::DAY_W-1:0]   day,
  input  logic [sdd_pkg::MONTH_W-1:0] month,
  input  logic [sdd_pkg::YEAR_W-1:0]  year,
  output logic [sdd_pkg::DN_W-1:0]    day_num,
  output logic                        ok
);
  import sdd_pkg::*;

  localparam logic [16:0] MaxYr = 17'(MAX_YEAR);

  // stage 1
  logic [YEAR_W-1:0]  yy_c;
  logic [PROD_W-1:0]  py_c;
  logic [PROD_W-1:0]  pyy_c;
  logic [DOY_W-1:0]   doy_c;

  logic [DAY_W-1:0]   d1;
  logic [MONTH_W-1:0] m1;
  logic [YEAR_W-1:0]  y1;
  logic [YEAR_W-1:0]  yy1;
  logic [DOY_W-1:0]   doy1;
  logic [Q100_W-1:0]  qy1;
  logic [Q100_W-1:0]  qyy1;

  always_comb begin
    yy_c  = (month <= 4'd2) ? year - YEAR_W'(1) : year;
    py_c  = PROD_W'(year) * PROD_W'(RECIP100);
    pyy_c = PROD_W'(yy_c) * PROD_W'(RECIP100);
    doy_c = month_base(month) + DOY_W'(day) - DOY_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d1   <= day;
      m1   <= month;
      y1   <= year;
      yy1  <= yy_c;
      doy1 <= doy_c;
      qy1  <= py_c[RECIP_SHFT +: Q100_W];
      qyy1 <= pyy_c[RECIP_SHFT +: Q100_W];
    end
  end

  // stage 2
  logic [YEAR_W-1:0] rem_c;
  logic              leap_c;
  logic [DAY_W-1:0]  last_c;
  logic              ok_c;
  logic [DN_W-1:0]   dn_c;

  always_comb begin
    rem_c  = y1 - YEAR_W'(qy1) * YEAR_W'(100);
    leap_c = (y1[1:0] == 2'd0) && ((rem_c != '0) || (qy1[1:0] == 2'd0));
    last_c = month_len(m1, leap_c);
    ok_c   = (m1 inside {[4'd1:4'd12]}) && (y1 != '0) && ({3'b0, y1} <= MaxYr)
             && (d1 != '0) && (d1 <= last_c);
    dn_c   = DN_W'(yy1) * DN_W'(365) + DN_W'(yy1 >> 2) - DN_W'(qyy1)
             + DN_W'(qyy1 >> 2) + DN_W'(doy1);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      day_num <= dn_c;
      ok      <= ok_c;
    end
  end

endmodule

/* src/sdd_merge.sv */
`timescale 1ns / 1ps
// merge stage: signed difference of the two day numbers, saturated, into the output register
// depends on sdd_pkg
module sdd_merge (
  input  logic                     clk,
  input  logic                     en,
  input  logic [sdd_pkg::DN_W-1:0] start_num,
  input  logic                     start_ok,
  input  logic [sdd_pkg::DN_W-1:0] end_num,
  input  logic                     end_ok,
  input  logic                     inc,
  output sdd_pkg::sdd_out_t        res
);
  import sdd_pkg::*;

  logic            earlier;
  logic [DN_W-1:0] gap;
  logic [DN_W:0]   mag;
  logic [DN_W:0]   mag_sat;
  sdd_out_t        res_next;

  always_comb begin
    earlier = start_num < end_num;
    gap     = earlier ? end_num - start_num : start_num - end_num;
    mag     = {1'b0, gap} + (DN_W+1)'(inc);
    mag_sat = (mag > DIFF_LIMIT) ? DIFF_LIMIT : mag;
    if (!(start_ok && end_ok)) begin
      res_next.day_difference = '0;
      res_next.date_invalid   = 1'b1;
    end else begin
      res_next.day_difference = earlier ? DIFF_W'(mag_sat) : DIFF_W'(-mag_sat);
      res_next.date_invalid   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

/* src/signed_date_difference_days_top.sv */
`timescale 1ns / 1ps
// Signed Gregorian day difference between a start and an end date. One word is taken
// every cycle unless stalled, and passes through two day-number stages in each
// of the two date lanes, then a merge stage that subtracts, applies the include-end-day
// flag, saturates and holds the result in the output register. Back-pressure from the
// result side stalls the whole pipeline; empty stages fill while the output waits.
// A date with a bad month, day or year gives 0 with date_invalid set.
// depends on sdd_pkg, sdd_lane, sdd_merge
module signed_date_difference_days_top #(
  parameter int MAX_YEAR = sdd_pkg::MAX_YEAR_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              date_valid,
  output logic              date_ready,
  input  sdd_pkg::sdd_in_t  date_data,
  output logic              diff_valid,
  input  logic              diff_ready,
  output sdd_pkg::sdd_out_t diff_data
);
  import sdd_pkg::*;

  logic     v1;
  logic     v2;
  logic     v3;
  logic     en3;
  logic     inc1;
  logic     inc2;
  sdd_adv_t adv;

  logic [DN_W-1:0] start_num;
  logic [DN_W-1:0] end_num;
  logic            start_ok;
  logic            end_ok;

  always_comb begin
    en3    = !v3 || diff_ready;
    adv.s2 = !v2 || en3;
    adv.s1 = !v1 || adv.s2;
  end

  assign date_ready = adv.s1;
  assign diff_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= date_valid;
      if (adv.s2) v2 <= v1;
      if (en3)    v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) inc1 <= date_data.include_end_day;
    if (adv.s2) inc2 <= inc1;
  end

  sdd_lane #(.MAX_YEAR(MAX_YEAR)) u_start_lane (
    .clk     (clk),
    .adv     (adv),
    .day     (date_data.start_day),
    .month   (date_data.start_month),
    .year    (date_data.start_year),
    .day_num (start_num),
    .ok      (start_ok)
  );

  sdd_lane #(.MAX_YEAR(MAX_YEAR)) u_end_lane (
    .clk     (clk),
    .adv     (adv),
    .day     (date_data.end_day),
    .month   (date_data.end_month),
    .year    (date_data.end_year),
    .day_num (end_num),
    .ok      (end_ok)
  );

  sdd_merge u_merge (
    .clk       (clk),
    .en        (en3),
    .start_num (start_num),
    .start_ok  (start_ok),
    .end_num   (end_num),
    .end_ok    (end_ok),
    .inc       (inc2),
    .res       (diff_data)
  );

endmodule

/* tb/tb_signed_date_difference_days_top.sv */
`timescale 1ns / 1ps
// testbench for signed_date_difference_days_top: directed and random date pairs,
// each result checked against a calendar day-count predictor held in the bench
// depends on sdd_pkg and signed_date_difference_days_top
module tb_signed_date_difference_days_top;
  import sdd_pkg::*;

  localparam int MAX_YEAR    = MAX_YEAR_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     date_valid = 1'b0;
  logic     date_ready;
  sdd_in_t  date_data = '0;
  logic     diff_valid;
  logic     diff_ready = 1'b0;
  sdd_out_t diff_data;

  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       mismatches = 0;
  int       cycles = 0;
  sdd_out_t pending_results[$];

  signed_date_difference_days_top #(.MAX_YEAR(MAX_YEAR)) dut (
    .clk        (clk),
    .rst        (rst),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date_data  (date_data),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff_data  (diff_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_leap(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int month_days(input int m, input int y);
    case (m)
      2:              return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic int days_before_month(input int m);
    case (m)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  function automatic bit real_date(input int d, input int m, input int y);
    if (m < 1 || m > 12) return 1'b0;
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    return d >= 1 && d <= month_days(m, y);
  endfunction

  // days counted from 1 jan of year 1
  function automatic longint calendar_index(input int d, input int m, input int y);
    longint py;
    longint n;
    py = y - 1;
    n = 365 * py + py / 4 - py / 100 + py / 400 + days_before_month(m) + d;
    if (m > 2 && is_leap(y)) n = n + 1;
    return n;
  endfunction

  function automatic sdd_out_t predict_difference(input sdd_in_t w);
    sdd_out_t r;
    longint   from_days;
    longint   to_days;
    longint   inc;
    longint   span;
    longint   lim;
    r = '0;
    if (!real_date(w.start_day, w.start_month, w.start_year) ||
        !real_date(w.end_day, w.end_month, w.end_year)) begin
      r.date_invalid = 1'b1;
      return r;
    end
    from_days = calendar_index(w.start_day, w.start_month, w.start_year);
    to_days   = calendar_index(w.end_day, w.end_month, w.end_year);
    inc       = w.include_end_day;
    lim       = DIFF_LIMIT;
    if (from_days < to_days) begin
      span = to_days - from_days + inc;
    end else begin
      span = -(from_days - to_days + inc);
    end
    if (span > lim) span = lim;
    if (span < -lim) span = -lim;
    r.day_difference = span[DIFF_W-1:0];
    return r;
  endfunction

  function automatic sdd_in_t make_word(input int sd, input int sm, input int sy,
                                        input int ed, input int em, input int ey,
                                        input bit inc);
    sdd_in_t w;
    w.start_day       = sd[DAY_W-1:0];
    w.start_month     = sm[MONTH_W-1:0];
    w.start_year      = sy[YEAR_W-1:0];
    w.end_day         = ed[DAY_W-1:0];
    w.end_month       = em[MONTH_W-1:0];
    w.end_year        = ey[YEAR_W-1:0];
    w.include_end_day = inc;
    return w;
  endfunction

  function automatic int pick_year();
    case ($urandom_range(9))
      0:       return $urandom_range(1, 99) * 100;
      1:       return $urandom_range(1, 24) * 400;
      2:       return $urandom_range(1, 2499) * 4;
      3:       return $urandom_range(1) ? 1 : MAX_YEAR;
      default: return $urandom_range(1, MAX_YEAR);
    endcase
  endfunction

  task automatic pick_date(output int d, output int m, output int y);
    y = pick_year();
    m = $urandom_range(1, 12);
    d = $urandom_range(1) ? $urandom_range(1, month_days(m, y)) : month_days(m, y);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_date(input sdd_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      date_valid <= 1'b0;
      @(posedge clk);
    end
    date_valid <= 1'b1;
    date_data  <= w;
    do @(posedge clk); while (!date_ready);
    pending_results.push_back(predict_difference(w));
  endtask

  // result side: random back-pressure and in-order comparison
  always @(posedge clk) begin
    sdd_out_t want;
    if (!rst && diff_valid && diff_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: diff %0d invalid %0b", $time,
                 diff_data.day_difference, diff_data.date_invalid);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (diff_data.day_difference !== want.day_difference) begin
          $display("%0t day_difference expected %0d actual %0d", $time,
                   want.day_difference, diff_data.day_difference);
          mismatches++;
        end
        if (diff_data.date_invalid !== want.date_invalid) begin
          $display("%0t date_invalid expected %0b actual %0b", $time,
                   want.date_invalid, diff_data.date_invalid);
          mismatches++;
        end
      end
    end
    diff_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_signed_date_difference_days_top NOT OK");
      $finish;
    end
  end

  task automatic test_extremes();
    send_date(make_word(15, 6, 2020, 15, 6, 2020, 1'b0));
    send_date(make_word(15, 6, 2020, 15, 6, 2020, 1'b1));
    send_date(make_word(1, 1, 1, 31, 12, MAX_YEAR, 1'b1));
    send_date(make_word(31, 12, MAX_YEAR, 1, 1, 1, 1'b1));
    send_date(make_word(1, 1, 1, 31, 12, MAX_YEAR, 1'b0));
    send_date(make_word(2, 3, 500, 1, 3, 500, 1'b0));
    send_date(make_word(1, 3, 500, 2, 3, 500, 1'b1));
    send_date(make_word(31, 1, 1999, 1, 2, 1999, 1'b0));
  endtask

  task automatic test_leap_rules();
    send_date(make_word(29, 2, 2000, 1, 3, 2000, 1'b0));
    send_date(make_word(28, 2, 1900, 1, 3, 1900, 1'b0));
    send_date(make_word(29, 2, 1900, 1, 3, 1900, 1'b0));
    send_date(make_word(29, 2, 2024, 29, 2, 2028, 1'b1));
    send_date(make_word(1, 1, 2023, 29, 2, 2023, 1'b0));
  endtask

  task automatic test_invalid_dates();
    send_date(make_word(1, 0, 2000, 1, 1, 2000, 1'b0));
    send_date(make_word(1, 1, 2000, 1, 13, 2000, 1'b1));
    send_date(make_word(31, 15, 16383, 31, 15, 16383, 1'b1));
    send_date(make_word(0, 5, 2000, 1, 5, 2000, 1'b0));
    send_date(make_word(31, 4, 2000, 1, 5, 2000, 1'b0));
    send_date(make_word(1, 1, 0, 1, 1, 2000, 1'b0));
    send_date(make_word(1, 1, 2000, 1, 1, MAX_YEAR + 1, 1'b1));
    send_date(make_word(0, 0, 0, 0, 0, 0, 1'b0));
  endtask

  task automatic test_random(input int count);
    int      sd, sm, sy, ed, em, ey;
    sdd_in_t w;
    for (int i = 0; i < count; i++) begin
      pick_date(sd, sm, sy);
      pick_date(ed, em, ey);
      case ($urandom_range(9))
        0, 1: begin
          // end close to start
          ey = sy;
          em = sm;
          ed = $urandom_range(1, month_days(sm, sy));
        end
        2: begin
          ed = sd;
          em = sm;
          ey = sy;
        end
        default: ;
      endcase
      w = make_word(sd, sm, sy, ed, em, ey, $urandom_range(1));
      case ($urandom_range(19))
        0, 1, 2: w = make_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(1));
        3: w.start_month = $urandom_range(1) ? 4'd0 : MONTH_W'($urandom_range(13, 15));
        4: w.end_day = $urandom_range(1) ? 5'd0 : DAY_W'(month_days(em, ey) + 1);
        5: w.start_year = $urandom_range(1) ? '0 : YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
        6: w.end_month = MONTH_W'($urandom_range(13, 15));
        default: ;
      endcase
      send_date(w);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_idling(29, 56);
    test_extremes();
    test_leap_rules();
    test_invalid_dates();
    test_random(430);
    set_idling(56, 29);
    test_random(430);
    set_idling(0, 0);
    test_random(440);
    date_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_signed_date_difference_days_top OK");
    end else begin
      $display("tb_signed_date_difference_days_top NOT OK");
    end
    $finish;
  end

endmodule
